### design/plct_pkg.sv
// Shared types and constants of the piecewise-linear calibration table.
// Used by the top level, plct_ctrl, plct_dp and plct_div; depends on nothing else.
package plct_pkg;

  // Request codes of the input channel.
  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_CLEAR  = 3'd2,
    REQ_LOOKUP = 3'd3,
    REQ_READ   = 3'd4
  } req_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PREP,
    ST_ENTRY,
    ST_SCAN0,
    ST_SCAN,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_FIN,
    ST_WRITE,
    ST_RDWAIT,
    ST_DONE
  } state_e;

  // Fixed field and arithmetic widths.
  localparam int unsigned ValW  = 16;
  localparam int unsigned NumW  = 32;
  localparam int unsigned DenW  = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic edit;
    logic set_ok;
    logic rd_done;
    logic prep;
    logic entry;
    logic scan0;
    logic scan;
    logic mul;
    logic div_start;
    logic fin;
    logic write;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_e req;
    logic edit_ok;
    logic lt2;
    logic below;
    logic above;
    logic hit;
    logic flat;
    logic p_last;
    logic ent_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

### design/piecewise_linear_calibration_table_core.sv
// Top level of the piecewise-linear calibration table.
// Depends on plct_pkg, plct_ctrl and plct_dp.
//
// Usage: one request is taken on the input channel (valid/stall) and exactly
// one result leaves on the output channel (valid/stall). Requests add, delete
// or clear anchors, look up a duty for a speed, or read one curve entry.
// The block works on one request at a time; in_stall_o is high from the
// transfer until the result has been loaded into the output register.
// An edit that succeeds rebuilds all CURVE_ENTRIES entries when at least two
// anchors remain, and otherwise marks the curve invalid. Entries that lie
// outside the anchors skip the scan; the others take a segment scan and,
// unless the segment is flat, the shared bit-serial divider.
// A waiting result does not block the next transfer on the input side; the
// block only holds its last step while the output register is still full
// and stalled. Reset empties the anchor list and marks the curve invalid;
// curve reads then return zero, so no clearing pass is needed.
module piecewise_linear_calibration_table_core #(
  parameter int unsigned MAX_ANCHORS     = 16,
  parameter int unsigned CURVE_ENTRIES   = 385,
  parameter int unsigned DUTY_BITS       = 12,
  parameter int unsigned DUTY_STEP_SHIFT = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] speed_i,
  input  logic [15:0] duty_i,
  input  logic [7:0]  point_index_i,
  input  logic [8:0]  table_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [15:0] value_o,
  output logic [4:0]  anchor_total_o,
  output logic        curve_valid_o
);

  plct_pkg::cmd_t cmd;
  plct_pkg::sts_t sts;

  // Sequencer.
  plct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic.
  plct_dp #(
    .MAX_ANCHORS     (MAX_ANCHORS),
    .CURVE_ENTRIES   (CURVE_ENTRIES),
    .DUTY_BITS       (DUTY_BITS),
    .DUTY_STEP_SHIFT (DUTY_STEP_SHIFT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_type_i),
    .speed_i        (speed_i),
    .duty_i         (duty_i),
    .point_index_i  (point_index_i),
    .table_index_i  (table_index_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .ok_o           (ok_o),
    .value_o        (value_o),
    .anchor_total_o (anchor_total_o),
    .curve_valid_o  (curve_valid_o)
  );

endmodule

### design/plct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing else.
module plct_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 385
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/plct_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on plct_pkg for the operand widths.
module plct_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [plct_pkg::NumW-1:0] num_i,
  input  logic [plct_pkg::DenW-1:0] den_i,
  output logic                      done_o,
  output logic [plct_pkg::NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(plct_pkg::NumW);

  logic                      busy_q, done_q;
  logic [CntW-1:0]           cnt_q;
  logic [plct_pkg::NumW-1:0] dq_q;
  logic [plct_pkg::DenW-1:0] rem_q, den_q;
  logic [plct_pkg::DenW:0]   trial;
  logic                      qbit;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_q, dq_q[plct_pkg::NumW-1]};
    qbit  = (trial >= {1'b0, den_q});
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(plct_pkg::NumW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(plct_pkg::NumW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? plct_pkg::DenW'(trial - {1'b0, den_q})
                    : trial[plct_pkg::DenW-1:0];
      dq_q  <= {dq_q[plct_pkg::NumW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = dq_q;

endmodule

### design/plct_dp.sv
// Datapath: anchor list, curve memory, interpolation arithmetic and the
// result register. Depends on plct_pkg, plct_ram and plct_div.
module plct_dp #(
  parameter int unsigned MAX_ANCHORS     = 16,
  parameter int unsigned CURVE_ENTRIES   = 385,
  parameter int unsigned DUTY_BITS       = 12,
  parameter int unsigned DUTY_STEP_SHIFT = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plct_pkg::cmd_t      cmd_i,
  output plct_pkg::sts_t      sts_o,
  input  logic [2:0]          req_type_i,
  input  logic [15:0]         speed_i,
  input  logic [15:0]         duty_i,
  input  logic [7:0]          point_index_i,
  input  logic [8:0]          table_index_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                ok_o,
  output logic [15:0]         value_o,
  output logic [4:0]          anchor_total_o,
  output logic                curve_valid_o
);

  localparam int unsigned AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
  localparam int unsigned CW = $clog2(MAX_ANCHORS + 1);
  localparam int unsigned EW = $clog2(CURVE_ENTRIES);
  localparam int unsigned DutyMax = (1 << DUTY_BITS) - 1;
  localparam int unsigned VW = plct_pkg::ValW;

  // Request fields.
  plct_pkg::req_e req_q;
  logic [15:0]    speed_q, duty_q;
  logic [7:0]     pidx_q;
  logic [8:0]     tidx_q;

  // Anchor list and flags.
  logic [15:0]          spd_q [MAX_ANCHORS];
  logic [DUTY_BITS-1:0] dty_q [MAX_ANCHORS];
  logic [15:0]          spd_d [MAX_ANCHORS];
  logic [DUTY_BITS-1:0] dty_d [MAX_ANCHORS];
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 cok_q;

  // Sequencing and arithmetic registers.
  logic [AW-1:0]  p_q;
  logic [EW-1:0]  ent_q;
  logic [VW-1:0]  last_x_q, last_y_q, prev_x_q, prev_y_q;
  logic [VW-1:0]  y_q, y0_q, rmax_q, mag_q, koff_q, dv_q;
  logic           neg_q;
  logic [plct_pkg::NumW-1:0] prod_q, quo;
  logic           div_done;

  // Result register.
  logic           res_ok_q, out_valid_q, ok_q, cv_q;
  logic [VW-1:0]  res_val_q, val_q;
  logic [4:0]     tot_q;

  // Combinational helpers.
  logic                 lookup, edit_ok, any_match, tidx_ok;
  logic [AW-1:0]        mpos, rd_idx;
  logic [CW-1:0]        pos;
  logic [DUTY_BITS-1:0] dcl;
  logic [VW-1:0]        key, cur_x, cur_y, x0, wval, rdata;
  logic [VW:0]          dnum;

  assign lookup  = (req_q == plct_pkg::REQ_LOOKUP);
  assign tidx_ok = (32'(tidx_q) < CURVE_ENTRIES);

  // Edit of the anchor list: add, delete or clear.
  always_comb begin
    dcl = (duty_q > 16'(DutyMax)) ? DUTY_BITS'(DutyMax) : duty_q[DUTY_BITS-1:0];
    any_match = 1'b0;
    mpos      = '0;
    pos       = cnt_q;
    for (int i = MAX_ANCHORS - 1; i >= 0; i--) begin
      if (CW'(i) < cnt_q && spd_q[i] == speed_q) begin
        any_match = 1'b1;
        mpos      = AW'(i);
      end
      if (CW'(i) < cnt_q && speed_q < spd_q[i]) begin
        pos = CW'(i);
      end
    end
    spd_d   = spd_q;
    dty_d   = dty_q;
    cnt_d   = cnt_q;
    edit_ok = 1'b0;
    case (req_q)
      plct_pkg::REQ_ADD: begin
        if (any_match) begin
          dty_d[mpos] = dcl;
          edit_ok     = 1'b1;
        end else if (cnt_q < CW'(MAX_ANCHORS)) begin
          for (int i = 0; i < MAX_ANCHORS; i++) begin
            if (CW'(i) == pos) begin
              spd_d[i] = speed_q;
              dty_d[i] = dcl;
            end else if (CW'(i) > pos && CW'(i) <= cnt_q) begin
              spd_d[i] = spd_q[(i > 0) ? i - 1 : 0];
              dty_d[i] = dty_q[(i > 0) ? i - 1 : 0];
            end
          end
          cnt_d   = cnt_q + CW'(1);
          edit_ok = 1'b1;
        end
      end
      plct_pkg::REQ_DELETE: begin
        if (9'(pidx_q) < 9'(cnt_q)) begin
          for (int i = 0; i < MAX_ANCHORS; i++) begin
            if (9'(i) >= 9'(pidx_q) && 9'(i + 1) < 9'(cnt_q)) begin
              spd_d[i] = spd_q[(i < MAX_ANCHORS - 1) ? i + 1 : i];
              dty_d[i] = dty_q[(i < MAX_ANCHORS - 1) ? i + 1 : i];
            end
          end
          cnt_d   = cnt_q - CW'(1);
          edit_ok = 1'b1;
        end
      end
      plct_pkg::REQ_CLEAR: begin
        cnt_d   = '0;
        edit_ok = 1'b1;
      end
      default: begin
        edit_ok = 1'b0;
      end
    endcase
  end

  // Anchor read port: x is the searched axis, y the interpolated one.
  always_comb begin
    rd_idx = cmd_i.prep ? AW'(cnt_q - CW'(1)) : p_q;
    cur_x  = lookup ? spd_q[rd_idx] : VW'(dty_q[rd_idx]);
    cur_y  = lookup ? VW'(dty_q[rd_idx]) : spd_q[rd_idx];
    x0     = lookup ? spd_q[0] : VW'(dty_q[0]);
    key    = lookup ? speed_q : (VW'(ent_q) << DUTY_STEP_SHIFT);
    dnum   = {1'b0, cur_y} - {1'b0, prev_y_q};
    wval   = (y_q > rmax_q) ? y_q : rmax_q;
  end

  // Status toward the controller.
  always_comb begin
    sts_o.req      = req_q;
    sts_o.edit_ok  = edit_ok;
    sts_o.lt2      = (cnt_q < CW'(2));
    sts_o.below    = (key < x0);
    sts_o.above    = (key >= last_x_q);
    sts_o.hit      = (prev_x_q <= key) && (key <= cur_x);
    sts_o.flat     = (cur_x == prev_x_q);
    sts_o.p_last   = (CW'(p_q) == cnt_q - CW'(1));
    sts_o.ent_last = (ent_q == EW'(CURVE_ENTRIES - 1));
    sts_o.div_done = div_done;
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

  // Control registers: anchor count, curve flag, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cok_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.edit) begin
        cnt_q <= cnt_d;
      end
      if (cmd_i.prep && sts_o.lt2 && !lookup) begin
        cok_q <= 1'b0;
      end
      if (cmd_i.write && !lookup && sts_o.ent_last) begin
        cok_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q     <= plct_pkg::req_e'(req_type_i);
      speed_q   <= speed_i;
      duty_q    <= duty_i;
      pidx_q    <= point_index_i;
      tidx_q    <= table_index_i;
      res_ok_q  <= 1'b0;
      res_val_q <= '0;
    end
    if (cmd_i.edit) begin
      spd_q    <= spd_d;
      dty_q    <= dty_d;
      res_ok_q <= edit_ok;
    end
    if (cmd_i.set_ok) begin
      res_ok_q <= 1'b1;
    end
    if (cmd_i.rd_done && tidx_ok) begin
      res_ok_q  <= 1'b1;
      res_val_q <= cok_q ? rdata : '0;
    end
    if (cmd_i.prep) begin
      last_x_q <= cur_x;
      last_y_q <= cur_y;
      ent_q    <= '0;
      rmax_q   <= '0;
    end
    if (cmd_i.entry) begin
      p_q <= '0;
      if (sts_o.below) begin
        y_q <= '0;
      end else if (sts_o.above) begin
        y_q <= last_y_q;
      end
    end
    if (cmd_i.scan0) begin
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
      p_q      <= p_q + AW'(1);
    end
    if (cmd_i.scan) begin
      if (sts_o.hit && sts_o.flat) begin
        y_q <= cur_y;
      end else if (sts_o.hit) begin
        y0_q   <= prev_y_q;
        neg_q  <= dnum[VW];
        mag_q  <= dnum[VW] ? VW'(-dnum) : dnum[VW-1:0];
        koff_q <= key - prev_x_q;
        dv_q   <= cur_x - prev_x_q;
      end else if (sts_o.p_last) begin
        y_q <= lookup ? last_y_q : '0;
      end else begin
        prev_x_q <= cur_x;
        prev_y_q <= cur_y;
        p_q      <= p_q + AW'(1);
      end
    end
    if (cmd_i.mul) begin
      prod_q <= plct_pkg::NumW'(mag_q) * plct_pkg::NumW'(koff_q);
    end
    if (cmd_i.fin) begin
      y_q <= neg_q ? y0_q - quo[VW-1:0] : y0_q + quo[VW-1:0];
    end
    if (cmd_i.write) begin
      if (lookup) begin
        res_val_q <= y_q;
      end else begin
        rmax_q <= wval;
        ent_q  <= ent_q + EW'(1);
      end
    end
    if (cmd_i.out_load) begin
      ok_q  <= res_ok_q;
      val_q <= res_val_q;
      tot_q <= 5'(cnt_q);
      cv_q  <= cok_q;
    end
  end

  // Shared divider for both interpolations.
  plct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_q),
    .den_i   (dv_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Curve memory.
  plct_ram #(
    .Width (VW),
    .Depth (CURVE_ENTRIES)
  ) u_curve (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write && !lookup),
    .waddr_i (ent_q),
    .wdata_i (wval),
    .raddr_i (EW'(tidx_q)),
    .rdata_o (rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign value_o        = val_q;
  assign anchor_total_o = tot_q;
  assign curve_valid_o  = cv_q;

endmodule

### design/plct_ctrl.sv
// Controller state machine that sequences the datapath.
// Depends on plct_pkg for the state, command and status types.
module plct_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  plct_pkg::sts_t sts_i,
  output plct_pkg::cmd_t cmd_o
);

  plct_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plct_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != plct_pkg::ST_IDLE);
    case (state_q)
      plct_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = plct_pkg::ST_DECODE;
        end
      end
      plct_pkg::ST_DECODE: begin
        case (sts_i.req)
          plct_pkg::REQ_ADD, plct_pkg::REQ_DELETE, plct_pkg::REQ_CLEAR: begin
            cmd_o.edit = 1'b1;
            state_d    = sts_i.edit_ok ? plct_pkg::ST_PREP : plct_pkg::ST_DONE;
          end
          plct_pkg::REQ_LOOKUP: begin
            cmd_o.set_ok = 1'b1;
            state_d      = plct_pkg::ST_PREP;
          end
          plct_pkg::REQ_READ: begin
            state_d = plct_pkg::ST_RDWAIT;
          end
          default: begin
            state_d = plct_pkg::ST_DONE;
          end
        endcase
      end
      plct_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.lt2 ? plct_pkg::ST_DONE : plct_pkg::ST_ENTRY;
      end
      plct_pkg::ST_ENTRY: begin
        cmd_o.entry = 1'b1;
        state_d = (sts_i.below || sts_i.above) ? plct_pkg::ST_WRITE : plct_pkg::ST_SCAN0;
      end
      plct_pkg::ST_SCAN0: begin
        cmd_o.scan0 = 1'b1;
        state_d     = plct_pkg::ST_SCAN;
      end
      plct_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit && sts_i.flat) begin
          state_d = plct_pkg::ST_WRITE;
        end else if (sts_i.hit) begin
          state_d = plct_pkg::ST_MUL;
        end else if (sts_i.p_last) begin
          state_d = plct_pkg::ST_WRITE;
        end
      end
      plct_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = plct_pkg::ST_DIVGO;
      end
      plct_pkg::ST_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = plct_pkg::ST_DIV;
      end
      plct_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = plct_pkg::ST_FIN;
        end
      end
      plct_pkg::ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = plct_pkg::ST_WRITE;
      end
      plct_pkg::ST_WRITE: begin
        cmd_o.write = 1'b1;
        if (sts_i.req == plct_pkg::REQ_LOOKUP || sts_i.ent_last) begin
          state_d = plct_pkg::ST_DONE;
        end else begin
          state_d = plct_pkg::ST_ENTRY;
        end
      end
      plct_pkg::ST_RDWAIT: begin
        cmd_o.rd_done = 1'b1;
        state_d       = plct_pkg::ST_DONE;
      end
      plct_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = plct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = plct_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### tb/piecewise_linear_calibration_table_core_tb.sv
// Self-checking testbench of the piecewise-linear calibration table core.
// Depends on plct_pkg and piecewise_linear_calibration_table_core only.
`timescale 1ns / 100ps

module piecewise_linear_calibration_table_core_tb;

  localparam int MaxAnchors   = 16;
  localparam int CurveEntries = 385;
  localparam int DutyMax      = 4095;
  localparam int StepShift    = 2;
  localparam int IdleLimit    = 200000;
  localparam int RandomItems  = 560;

  typedef struct {
    logic [2:0]  req;
    logic [15:0] speed;
    logic [15:0] duty;
    logic [7:0]  pidx;
    logic [8:0]  tidx;
  } request_t;

  typedef struct {
    logic        ok;
    logic [15:0] value;
    logic [4:0]  total;
    logic        cv;
  } answer_t;

  typedef struct {
    request_t rq;
    bit       typed;
    answer_t  ans;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  req_type_i = '0;
  logic [15:0] speed_i = '0;
  logic [15:0] duty_i = '0;
  logic [7:0]  point_index_i = '0;
  logic [8:0]  table_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        ok_o;
  logic [15:0] value_o;
  logic [4:0]  anchor_total_o;
  logic        curve_valid_o;

  piecewise_linear_calibration_table_core dut (.*);

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the anchor list and the curve.
  logic [15:0] anc_speed[MaxAnchors];
  logic [15:0] anc_duty[MaxAnchors];
  int          anc_count = 0;
  logic [15:0] curve[CurveEntries];
  bit          curve_built = 0;

  answer_t answer_q[$];
  row_t    typed_q[$];
  int      errors = 0;
  int      checked = 0;
  int      req_seen[8];
  bit      full_hits = 0;

  // Rebuild the speed curve from the anchors, then apply a running maximum.
  function automatic void rebuild_curve();
    int     d, d0, d1;
    longint s0, s1, sp;
    for (int i = 0; i < CurveEntries; i++) curve[i] = '0;
    if (anc_count < 2) begin
      curve_built = 0;
      return;
    end
    for (int i = 0; i < CurveEntries; i++) begin
      d = i << StepShift;
      if (d < anc_duty[0]) begin
        curve[i] = '0;
      end else if (d >= anc_duty[anc_count-1]) begin
        curve[i] = anc_speed[anc_count-1];
      end else begin
        for (int p = 0; p + 1 < anc_count; p++) begin
          d0 = anc_duty[p];
          d1 = anc_duty[p+1];
          if (d >= d0 && d <= d1) begin
            s0 = anc_speed[p];
            s1 = anc_speed[p+1];
            if (d1 == d0) sp = s1;
            else sp = s0 + ((s1 - s0) * longint'(d - d0)) / longint'(d1 - d0);
            if (sp < 0) sp = 0;
            if (sp > 65535) sp = 65535;
            curve[i] = sp[15:0];
            break;
          end
        end
      end
    end
    for (int i = 1; i < CurveEntries; i++)
      if (curve[i] < curve[i-1]) curve[i] = curve[i-1];
    curve_built = 1;
  endfunction

  // Interpolate a duty directly from the anchors; falling segments truncate
  // toward zero.
  function automatic int duty_for_speed(int spd);
    longint d0, d1, r;
    int     s0, s1;
    if (anc_count < 2) return 0;
    if (spd <= anc_speed[0]) return (spd < anc_speed[0]) ? 0 : anc_duty[0];
    if (spd >= anc_speed[anc_count-1]) return anc_duty[anc_count-1];
    for (int p = 0; p + 1 < anc_count; p++) begin
      s0 = anc_speed[p];
      s1 = anc_speed[p+1];
      if (spd >= s0 && spd <= s1) begin
        d0 = anc_duty[p];
        d1 = anc_duty[p+1];
        if (s1 == s0) return int'(d1);
        r = d0 + ((d1 - d0) * longint'(spd - s0)) / longint'(s1 - s0);
        if (r < 0) r = 0;
        return int'(r);
      end
    end
    return anc_duty[anc_count-1];
  endfunction

  // Apply one request to the shadow state and return the answer it causes.
  function automatic answer_t apply_request(request_t rq);
    answer_t a;
    int      dty, pos;
    bit      done;
    a.ok = 0;
    a.value = '0;
    done = 0;
    case (rq.req)
      plct_pkg::REQ_ADD: begin
        dty = (rq.duty > DutyMax) ? DutyMax : rq.duty;
        for (int i = 0; i < anc_count && !done; i++)
          if (anc_speed[i] == rq.speed) begin
            anc_duty[i] = dty[15:0];
            done = 1;
          end
        if (!done && anc_count < MaxAnchors) begin
          pos = anc_count;
          for (int i = 0; i < anc_count; i++)
            if (rq.speed < anc_speed[i]) begin
              pos = i;
              break;
            end
          for (int i = anc_count; i > pos; i--) begin
            anc_speed[i] = anc_speed[i-1];
            anc_duty[i] = anc_duty[i-1];
          end
          anc_speed[pos] = rq.speed;
          anc_duty[pos] = dty[15:0];
          anc_count++;
          done = 1;
        end
        if (!done) full_hits = 1;
        if (done) rebuild_curve();
        a.ok = done;
      end
      plct_pkg::REQ_DELETE: begin
        if (rq.pidx < anc_count) begin
          for (int i = rq.pidx; i + 1 < anc_count; i++) begin
            anc_speed[i] = anc_speed[i+1];
            anc_duty[i] = anc_duty[i+1];
          end
          anc_count--;
          rebuild_curve();
          a.ok = 1;
        end
      end
      plct_pkg::REQ_CLEAR: begin
        anc_count = 0;
        rebuild_curve();
        a.ok = 1;
      end
      plct_pkg::REQ_LOOKUP: begin
        a.value = 16'(duty_for_speed(rq.speed));
        a.ok = 1;
      end
      plct_pkg::REQ_READ: begin
        if (rq.tidx < CurveEntries) begin
          a.value = curve[rq.tidx];
          a.ok = 1;
        end
      end
      default: ;
    endcase
    a.total = anc_count[4:0];
    a.cv = curve_built;
    return a;
  endfunction

  // Predict on every input transfer; directed rows with a typed answer use it.
  always @(posedge clk_i) begin
    answer_t a;
    row_t    r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      a = apply_request('{req_type_i, speed_i, duty_i, point_index_i, table_index_i});
      req_seen[req_type_i]++;
      if (typed_q.size() > 0) begin
        r = typed_q.pop_front();
        if (r.typed) a = r.ans;
      end
      answer_q.push_back(a);
    end
  end

  // Compare each output transfer with the oldest expected answer.
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answer_q.size() == 0) begin
        $error("result with no request waiting");
        errors++;
      end else begin
        e = answer_q.pop_front();
        checked++;
        if (ok_o !== e.ok) begin
          $error("ok: expected %0d, got %0d", e.ok, ok_o);
          errors++;
        end
        if (value_o !== e.value) begin
          $error("value: expected %0d, got %0d", e.value, value_o);
          errors++;
        end
        if (anchor_total_o !== e.total) begin
          $error("anchor_total: expected %0d, got %0d", e.total, anchor_total_o);
          errors++;
        end
        if (curve_valid_o !== e.cv) begin
          $error("curve_valid: expected %0d, got %0d", e.cv, curve_valid_o);
          errors++;
        end
      end
    end
  end

  // Receiver stalls in runs of random length, with long free stretches.
  int stall_run = 0;
  int stall_pct = 0;
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_run = $urandom_range(1, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
    end
    stall_run--;
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog on cycles with no transfer on either channel.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drive one request; the sender may pause between bursts of random length.
  int burst_left = 0;
  task automatic send(request_t rq);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    req_type_i    <= rq.req;
    speed_i       <= rq.speed;
    duty_i        <= rq.duty;
    point_index_i <= rq.pidx;
    table_index_i <= rq.tidx;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
  endtask

  // Random requests: mostly edits with close duties, lookups and reads.
  bit wide_pending = 0;
  function automatic request_t random_request();
    request_t rq;
    int       pick;
    rq.speed = 16'($urandom_range(0, 65535));
    rq.duty = 16'($urandom_range(0, 65535));
    rq.pidx = 8'($urandom_range(0, 255));
    rq.tidx = 9'($urandom_range(0, 511));
    pick = $urandom_range(0, 99);
    // A wide duty makes every later rebuild slow, so it is cleared at once.
    if (wide_pending) begin
      rq.req = plct_pkg::REQ_CLEAR;
      wide_pending = 0;
      return rq;
    end
    if (pick < 38) begin
      rq.req = plct_pkg::REQ_ADD;
      if ($urandom_range(0, 39) == 0) wide_pending = 1;
      else rq.duty = 16'($urandom_range(0, 160));
      if (anc_count > 0 && $urandom_range(0, 5) == 0)
        rq.speed = anc_speed[$urandom_range(0, anc_count - 1)];
    end else if (pick < 50) begin
      rq.req = plct_pkg::REQ_DELETE;
      if ($urandom_range(0, 4) != 0) rq.pidx = 8'($urandom_range(0, anc_count + 1));
    end else if (pick < 53) begin
      rq.req = plct_pkg::REQ_CLEAR;
    end else if (pick < 75) begin
      rq.req = plct_pkg::REQ_LOOKUP;
      if (anc_count > 0 && $urandom_range(0, 2) == 0)
        rq.speed = 16'(anc_speed[$urandom_range(0, anc_count - 1)]
                       + $urandom_range(0, 2) - 1);
    end else if (pick < 95) begin
      rq.req = plct_pkg::REQ_READ;
      if ($urandom_range(0, 3) != 0) rq.tidx = 9'($urandom_range(0, 60));
    end else begin
      rq.req = 3'($urandom_range(5, 7));
    end
    return rq;
  endfunction

  // Directed rows; typed answers are those readable at a glance.
  row_t rows[$] = '{
    '{'{plct_pkg::REQ_READ, 16'd0, 16'd0, 8'd0, 9'd0}, 1, '{1, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_LOOKUP, 16'd1000, 16'd0, 8'd0, 9'd0}, 1, '{1, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_READ, 16'd0, 16'd0, 8'd0, 9'd385}, 1, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_READ, 16'd0, 16'd0, 8'd0, 9'd511}, 1, '{0, 16'd0, 5'd0, 0}},
    '{'{3'd5, 16'd0, 16'd0, 8'd0, 9'd0}, 1, '{0, 16'd0, 5'd0, 0}},
    '{'{3'd7, 16'hFFFF, 16'hFFFF, 8'hFF, 9'h1FF}, 1, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_DELETE, 16'd0, 16'd0, 8'd0, 9'd0}, 1, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_CLEAR, 16'd0, 16'd0, 8'd0, 9'd0}, 1, '{1, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_ADD, 16'd0, 16'hFFFF, 8'd0, 9'd0}, 1, '{1, 16'd0, 5'd1, 0}},
    '{'{plct_pkg::REQ_ADD, 16'hFFFF, 16'd0, 8'd0, 9'd0}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_LOOKUP, 16'd32768, 16'd0, 8'd0, 9'd0}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_LOOKUP, 16'hFFFF, 16'd0, 8'd0, 9'd0}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_ADD, 16'd0, 16'd100, 8'd0, 9'd0}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_ADD, 16'd1000, 16'd40, 8'd0, 9'd0}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_READ, 16'd0, 16'd0, 8'd0, 9'd10}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_READ, 16'd0, 16'd0, 8'd0, 9'd384}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_LOOKUP, 16'd0, 16'd0, 8'd0, 9'd0}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_LOOKUP, 16'd500, 16'd0, 8'd0, 9'd0}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_DELETE, 16'd0, 16'd0, 8'd1, 9'd0}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_DELETE, 16'd0, 16'd0, 8'd255, 9'd0}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_ADD, 16'd500, 16'd20, 8'd0, 9'd0}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_LOOKUP, 16'd250, 16'd0, 8'd0, 9'd0}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_READ, 16'd0, 16'd0, 8'd0, 9'd3}, 0, '{0, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_CLEAR, 16'd0, 16'd0, 8'd0, 9'd0}, 1, '{1, 16'd0, 5'd0, 0}},
    '{'{plct_pkg::REQ_READ, 16'd0, 16'd0, 8'd0, 9'd0}, 1, '{1, 16'd0, 5'd0, 0}}
  };

  // Main sequence: reset, directed rows, random requests, then drain.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      // Every row is queued so the monitor knows whether its answer is typed.
      typed_q.push_back(rows[i]);
      send(rows[i].rq);
    end
    for (int n = 0; n < RandomItems; n++) send(random_request());
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (answer_q.size() != 0) begin
      $error("%0d expected results never arrived", answer_q.size());
      errors++;
    end
    $display("Covered %0d results: add %0d, delete %0d, clear %0d, lookup %0d, read %0d.",
             checked, req_seen[plct_pkg::REQ_ADD], req_seen[plct_pkg::REQ_DELETE],
             req_seen[plct_pkg::REQ_CLEAR], req_seen[plct_pkg::REQ_LOOKUP],
             req_seen[plct_pkg::REQ_READ]);
    $display("Unknown requests %0d, full list reached: %0d, mismatches %0d.",
             req_seen[5] + req_seen[6] + req_seen[7], full_hits, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
